[design/koc_pkg.sv]
// ----------------------------------------------------------------------------
// koc_pkg
// Shared widths, codes and types of the key occurrence counter.
// ----------------------------------------------------------------------------
package koc_pkg;

   localparam int KEY_W               = 20;
   localparam int CODE_W              = 30;
   localparam int COUNT_W             = 16;
   localparam int SCALE_W             = 10;
   localparam int TABLE_DEPTH_DEFAULT = 64;

   // front-to-back item queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SCALE_W-1:0] GROUP_SCALE = SCALE_W'(1000);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   typedef enum logic [0:0] {
      MODE_COUNT = 1'b0,
      MODE_DUMP  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_LOOKUP,
      ST_UPDATE,
      ST_DUMP
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [KEY_W-1:0]   key;
      logic [CODE_W-1:0]  code;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] occurrence;
      logic               first_seen;
      logic               overflow;
      logic [CODE_W-1:0]  combined_code;
      logic [KEY_W-1:0]   entry_key;
      logic               entry_valid;
      logic               last;
   } rsp_type;

endpackage

[design/koc_front.sv]
// ----------------------------------------------------------------------------
// koc_front
// Request side: classifies items and forms the combined group/key code.
// ----------------------------------------------------------------------------
module koc_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [koc_pkg::KEY_W-1:0]   req_key,
   input  logic [koc_pkg::KEY_W-1:0]   req_group_code,
   output logic                        push,
   output koc_pkg::item_type           push_item,
   input  logic                        queue_full
);

   logic [koc_pkg::CODE_W-1:0] code;

   assign code = koc_pkg::CODE_W'(req_group_code) * koc_pkg::CODE_W'(koc_pkg::GROUP_SCALE)
               + koc_pkg::CODE_W'(req_key);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.mode = koc_pkg::mode_type'(req_mode);
      push_item.key  = req_key;
      // dump items carry no code
      push_item.code = (push_item.mode == koc_pkg::MODE_COUNT) ? code : '0;
   end

endmodule

[design/koc_queue.sv]
// ----------------------------------------------------------------------------
// koc_queue
// Short item queue between the request front and the table engine.
// ----------------------------------------------------------------------------
module koc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  koc_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output koc_pkg::item_type  head_item
);

   koc_pkg::item_type                 slot_ff [koc_pkg::QUEUE_DEPTH];
   logic [koc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [koc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [koc_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full       = (count_ff == koc_pkg::QCNT_W'(koc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == koc_pkg::QPTR_W'(koc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == koc_pkg::QPTR_W'(koc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/koc_back.sv]
// ----------------------------------------------------------------------------
// koc_back
// Table engine: key match array, count and key memories, result register.
// ----------------------------------------------------------------------------
module koc_back #(
   parameter int TABLE_DEPTH = koc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  koc_pkg::item_type  head_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output koc_pkg::rsp_type   rsp
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // match array: one key register per entry, compared in parallel
   logic [koc_pkg::KEY_W-1:0]   cam_ff       [TABLE_DEPTH];
   // copies for ordered readout, and hit counts
   logic [koc_pkg::KEY_W-1:0]   key_mem_ff   [TABLE_DEPTH];
   logic [koc_pkg::COUNT_W-1:0] count_mem_ff [TABLE_DEPTH];

   koc_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]            used_ff, used_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        hit_ff, hit_in;
   logic [koc_pkg::KEY_W-1:0]   item_key_ff, item_key_in;
   logic [koc_pkg::CODE_W-1:0]  item_code_ff, item_code_in;
   logic [IDX_W-1:0]            dump_idx_ff, dump_idx_in;
   logic [koc_pkg::KEY_W-1:0]   key_rd_ff;
   logic [koc_pkg::COUNT_W-1:0] count_rd_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   koc_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        match_any;
   logic [IDX_W-1:0]            match_idx;
   logic                        out_free;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic                        append;
   logic                        cnt_we;
   logic [IDX_W-1:0]            cnt_wr_addr;
   logic [koc_pkg::COUNT_W-1:0] cnt_wr_data;
   logic [koc_pkg::COUNT_W-1:0] count_sat;
   logic                        room;
   logic                        dump_end;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign room      = (used_ff < CNT_W'(TABLE_DEPTH));
   assign dump_end  = (used_ff == '0) || ((CNT_W'(dump_idx_ff) + 1'b1) == used_ff);
   assign count_sat = (count_rd_ff == koc_pkg::COUNT_MAX) ? count_rd_ff
                                                         : count_rd_ff + 1'b1;

   // keys in the table are distinct, so at most one entry matches
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if ((CNT_W'(i) < used_ff) && (cam_ff[i] == head_item.key)) begin
            match_any = 1'b1;
            match_idx = match_idx | IDX_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         koc_pkg::ST_LOOKUP: begin
            if (head_valid) begin
               state_in = (head_item.mode == koc_pkg::MODE_COUNT) ?
                          koc_pkg::ST_UPDATE : koc_pkg::ST_DUMP;
            end
         end
         koc_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = koc_pkg::ST_LOOKUP;
            end
         end
         koc_pkg::ST_DUMP: begin
            if (out_free && dump_end) begin
               state_in = koc_pkg::ST_LOOKUP;
            end
         end
         default: state_in = koc_pkg::ST_LOOKUP;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      append       = 1'b0;
      cnt_we       = 1'b0;
      cnt_wr_addr  = idx_ff;
      cnt_wr_data  = count_sat;
      used_in      = used_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      item_key_in  = item_key_ff;
      item_code_in = item_code_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         koc_pkg::ST_LOOKUP: begin
            if (head_valid) begin
               pop          = 1'b1;
               rd_en        = 1'b1;
               item_key_in  = head_item.key;
               item_code_in = head_item.code;
               dump_idx_in  = '0;
               if (head_item.mode == koc_pkg::MODE_COUNT) begin
                  rd_addr = match_idx;
                  idx_in  = match_idx;
                  hit_in  = match_any;
               end
            end
         end
         koc_pkg::ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.combined_code = item_code_ff;
               rsp_in.entry_key     = item_key_ff;
               rsp_in.entry_valid   = 1'b1;
               rsp_in.last          = 1'b1;
               rsp_in.first_seen    = 1'b0;
               rsp_in.overflow      = 1'b0;
               if (hit_ff) begin
                  cnt_we            = 1'b1;
                  rsp_in.occurrence = count_sat;
               end else if (room) begin
                  append            = 1'b1;
                  cnt_we            = 1'b1;
                  cnt_wr_addr       = used_ff[IDX_W-1:0];
                  cnt_wr_data       = koc_pkg::COUNT_W'(1);
                  used_in           = used_ff + 1'b1;
                  rsp_in.occurrence = koc_pkg::COUNT_W'(1);
                  rsp_in.first_seen = 1'b1;
               end else begin
                  rsp_in.occurrence = '0;
                  rsp_in.overflow   = 1'b1;
               end
            end
         end
         koc_pkg::ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.first_seen    = 1'b0;
               rsp_in.overflow      = 1'b0;
               rsp_in.combined_code = '0;
               rsp_in.last          = dump_end;
               if (used_ff == '0) begin
                  rsp_in.occurrence  = '0;
                  rsp_in.entry_key   = '0;
                  rsp_in.entry_valid = 1'b0;
               end else begin
                  rsp_in.occurrence  = count_rd_ff;
                  rsp_in.entry_key   = key_rd_ff;
                  rsp_in.entry_valid = 1'b1;
               end
               if (!dump_end) begin
                  rd_en       = 1'b1;
                  rd_addr     = dump_idx_ff + 1'b1;
                  dump_idx_in = dump_idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= koc_pkg::ST_LOOKUP;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      item_key_ff  <= item_key_in;
      item_code_ff <= item_code_in;
      dump_idx_ff  <= dump_idx_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (append) begin
         cam_ff[used_ff[IDX_W-1:0]]     <= item_key_ff;
         key_mem_ff[used_ff[IDX_W-1:0]] <= item_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem_ff[cnt_wr_addr] <= cnt_wr_data;
      end
      if (rd_en) begin
         count_rd_ff <= count_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_rd_ff <= key_mem_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[design/key_occurrence_counter_top.sv]
// A count item passes through the queue, a match lookup state and a count update
// state, which loads the result register; a dump then gives one entry per cycle
// while the output does not stall. The engine takes no new item until the last
// one is through; a dump gives one result per stored entry, or one for an empty table.
// Reset clears the entry count, the queue and the result valid flag; no
// clearing pass runs, so items are taken the cycle after reset drops.
// ----------------------------------------------------------------------------
// key_occurrence_counter_top
// Counts key occurrences in a first-arrival table and dumps it on request.
// ----------------------------------------------------------------------------
module key_occurrence_counter_top #(
   parameter int TABLE_DEPTH = koc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [koc_pkg::KEY_W-1:0]     req_key,
   input  logic [koc_pkg::KEY_W-1:0]     req_group_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [koc_pkg::COUNT_W-1:0]   rsp_occurrence,
   output logic                          rsp_first_seen,
   output logic                          rsp_overflow,
   output logic [koc_pkg::CODE_W-1:0]    rsp_combined_code,
   output logic [koc_pkg::KEY_W-1:0]     rsp_entry_key,
   output logic                          rsp_entry_valid,
   output logic                          rsp_last
);

   logic               push;
   koc_pkg::item_type  push_item;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   koc_pkg::item_type  head_item;
   koc_pkg::rsp_type   rsp;

   koc_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_group_code (req_group_code),
      .push           (push),
      .push_item      (push_item),
      .queue_full     (queue_full)
   );

   koc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   koc_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_occurrence    = rsp.occurrence;
   assign rsp_first_seen    = rsp.first_seen;
   assign rsp_overflow      = rsp.overflow;
   assign rsp_combined_code = rsp.combined_code;
   assign rsp_entry_key     = rsp.entry_key;
   assign rsp_entry_valid   = rsp.entry_valid;
   assign rsp_last          = rsp.last;

endmodule

[tb/key_occurrence_counter_top_tb.sv]
// ----------------------------------------------------------------------------
// key_occurrence_counter_top_tb
// Self-checking bench for the key occurrence counter. A queue-fed driver
// sends count and dump items while a clocked monitor predicts every result
// from a local copy of the key table and compares each one field by field.
// The run covers an empty dump, field extremes, table fill and overflow
// and full-table dumps, under changing idle patterns.
// ----------------------------------------------------------------------------
module key_occurrence_counter_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          TABLE_DEPTH = 64;
   localparam int unsigned CODE_SCALE  = 1000;
   localparam int          MAX_REPORTS = 10;

   typedef struct {
      koc_pkg::mode_type          mode;
      logic [koc_pkg::KEY_W-1:0]  key;
      logic [koc_pkg::KEY_W-1:0]  group;
      bit                         hold;   // wait until all tallies are back before sending
   } key_item_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_mode = 1'b0;
   logic [koc_pkg::KEY_W-1:0]   req_key = '0;
   logic [koc_pkg::KEY_W-1:0]   req_group_code = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [koc_pkg::COUNT_W-1:0] rsp_occurrence;
   logic                        rsp_first_seen;
   logic                        rsp_overflow;
   logic [koc_pkg::CODE_W-1:0]  rsp_combined_code;
   logic [koc_pkg::KEY_W-1:0]   rsp_entry_key;
   logic                        rsp_entry_valid;
   logic                        rsp_last;

   key_occurrence_counter_top #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_key           (req_key),
      .req_group_code    (req_group_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_occurrence    (rsp_occurrence),
      .rsp_first_seen    (rsp_first_seen),
      .rsp_overflow      (rsp_overflow),
      .rsp_combined_code (rsp_combined_code),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted table
   logic [koc_pkg::KEY_W-1:0]   tab_key   [TABLE_DEPTH];
   logic [koc_pkg::COUNT_W-1:0] tab_count [TABLE_DEPTH];
   int                          tab_used = 0;

   koc_pkg::rsp_type tally_q[$];     // expected results, oldest first
   key_item_type     key_item_q[$];  // items waiting for the driver
   bit               req_busy = 1'b0;

   // generator view of which keys end up stored
   logic [koc_pkg::KEY_W-1:0] gen_keys[$];
   bit                        gen_has_key[logic [koc_pkg::KEY_W-1:0]];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int fail_count      = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int dump_items      = 0;
   int overflow_hits   = 0;
   int saturated_hits  = 0;

   function automatic void flag_error(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t ERROR: %s", $realtime, what);
   endfunction

   function automatic void cmp_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (got !== want)
         flag_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
   endfunction

   task automatic model_tally(input koc_pkg::mode_type mode,
                              input logic [koc_pkg::KEY_W-1:0] key,
                              input logic [koc_pkg::KEY_W-1:0] group);
      koc_pkg::rsp_type r;
      int               hit;
      logic [31:0]      code;
      r   = '0;
      hit = -1;
      if (mode == koc_pkg::MODE_DUMP) begin
         dump_items++;
         if (tab_used == 0) begin
            r.last = 1'b1;
            tally_q = {tally_q, r};
         end else begin
            for (int i = 0; i < tab_used; i++) begin
               r             = '0;
               r.occurrence  = tab_count[i];
               r.entry_key   = tab_key[i];
               r.entry_valid = 1'b1;
               r.last        = (i == tab_used - 1);
               tally_q = {tally_q, r};
            end
         end
      end else begin
         code            = 32'(group) * CODE_SCALE + 32'(key);
         r.combined_code = code[koc_pkg::CODE_W-1:0];
         r.entry_key     = key;
         r.entry_valid   = 1'b1;
         r.last          = 1'b1;
         for (int i = 0; i < tab_used; i++)
            if (hit < 0 && tab_key[i] == key) hit = i;
         if (hit >= 0) begin
            if (tab_count[hit] == '1) saturated_hits++;
            else tab_count[hit] = tab_count[hit] + 1'b1;
            r.occurrence = tab_count[hit];
         end else if (tab_used < TABLE_DEPTH) begin
            tab_key[tab_used]   = key;
            tab_count[tab_used] = 1;
            tab_used++;
            r.occurrence = 1;
            r.first_seen = 1'b1;
         end else begin
            // table full: nothing stored
            r.overflow = 1'b1;
            overflow_hits++;
         end
         tally_q = {tally_q, r};
      end
   endtask

   task automatic check_tally(input koc_pkg::rsp_type got);
      koc_pkg::rsp_type want;
      if (tally_q.size() == 0) begin
         flag_error($sformatf("unexpected result, entry_key 0x%0h", got.entry_key));
      end else begin
         want = tally_q.pop_front();
         cmp_field("occurrence",    32'(want.occurrence),    32'(got.occurrence));
         cmp_field("first_seen",    32'(want.first_seen),    32'(got.first_seen));
         cmp_field("overflow",      32'(want.overflow),      32'(got.overflow));
         cmp_field("combined_code", 32'(want.combined_code), 32'(got.combined_code));
         cmp_field("entry_key",     32'(want.entry_key),     32'(got.entry_key));
         cmp_field("entry_valid",   32'(want.entry_valid),   32'(got.entry_valid));
         cmp_field("last",          32'(want.last),          32'(got.last));
      end
   endtask

   // driver: payload changes on the falling edge only
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_busy) begin
            if (key_item_q.size() != 0 && !(key_item_q[0].hold && tally_q.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               req_valid      <= 1'b1;
               req_mode       <= key_item_q[0].mode;
               req_key        <= key_item_q[0].key;
               req_group_code <= key_item_q[0].group;
               void'(key_item_q.pop_front());
               req_busy = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: both channels sampled on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            model_tally(koc_pkg::mode_type'(req_mode), req_key, req_group_code);
            req_busy = 1'b0;
            items_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            check_tally({rsp_occurrence, rsp_first_seen, rsp_overflow, rsp_combined_code,
                         rsp_entry_key, rsp_entry_valid, rsp_last});
            results_checked++;
         end
      end
   end

   function automatic logic [koc_pkg::KEY_W-1:0] rand_field();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return koc_pkg::KEY_W'($urandom);
      endcase
   endfunction

   function automatic logic [koc_pkg::KEY_W-1:0] fresh_key();
      logic [koc_pkg::KEY_W-1:0] k;
      do begin
         case ($urandom_range(3))
            // one bit away from a stored key stresses the parallel compare
            0: k = (gen_keys.size() != 0)
                   ? gen_keys[$urandom_range(gen_keys.size() - 1)]
                     ^ (koc_pkg::KEY_W'(1) << $urandom_range(koc_pkg::KEY_W - 1))
                   : koc_pkg::KEY_W'($urandom);
            1: k = $urandom_range(1)
                   ? koc_pkg::KEY_W'('1) - koc_pkg::KEY_W'($urandom_range(7))
                   : koc_pkg::KEY_W'($urandom_range(7));
            default: k = koc_pkg::KEY_W'($urandom);
         endcase
      end while (gen_has_key.exists(k));
      return k;
   endfunction

   task automatic queue_item(input koc_pkg::mode_type m,
                             input logic [koc_pkg::KEY_W-1:0] k,
                             input logic [koc_pkg::KEY_W-1:0] g, input bit hold = 1'b0);
      key_item_type it;
      it.mode  = m;
      it.key   = k;
      it.group = g;
      it.hold  = hold;
      key_item_q = {key_item_q, it};
      if (m == koc_pkg::MODE_COUNT && !gen_has_key.exists(k)
          && gen_keys.size() < TABLE_DEPTH) begin
         gen_has_key[k] = 1'b1;
         gen_keys = {gen_keys, k};
      end
   endtask

   task automatic queue_random(input int count);
      int unsigned roll;
      bit          hold;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         hold = ($urandom_range(24) == 0);
         if (roll < 10)
            queue_item(koc_pkg::MODE_DUMP, rand_field(), rand_field(), hold);
         else if (roll < ((gen_keys.size() < TABLE_DEPTH) ? 82 : 35))
            queue_item(koc_pkg::MODE_COUNT, fresh_key(), rand_field(), hold);
         else
            queue_item(koc_pkg::MODE_COUNT, gen_keys[$urandom_range(gen_keys.size() - 1)],
                       rand_field(), hold);
      end
   endtask

   task automatic wait_quiet();
      forever begin
         @(posedge clock);
         #1;
         if (key_item_q.size() == 0 && !req_busy && tally_q.size() == 0) break;
      end
   endtask

   initial begin
      send_idle_pct = 7;
      recv_idle_pct = 63;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty dump, field extremes, hits, near-miss keys
      queue_item(koc_pkg::MODE_DUMP,  20'hFFFFF, 20'hFFFFF, 1'b1);
      queue_item(koc_pkg::MODE_COUNT, 20'h00000, 20'h00000);
      queue_item(koc_pkg::MODE_COUNT, 20'h00000, 20'hFFFFF);
      queue_item(koc_pkg::MODE_COUNT, 20'hFFFFF, 20'hFFFFF);
      queue_item(koc_pkg::MODE_COUNT, 20'd999999, 20'd999999);
      queue_item(koc_pkg::MODE_COUNT, 20'hFFFFF, 20'h00000);
      queue_item(koc_pkg::MODE_COUNT, 20'h55555, 20'hAAAAA);
      queue_item(koc_pkg::MODE_COUNT, 20'hAAAAA, 20'h55555);
      queue_item(koc_pkg::MODE_DUMP,  20'h00000, 20'h00000, 1'b1);
      queue_item(koc_pkg::MODE_COUNT, 20'hFFFFE, 20'h00001);
      queue_item(koc_pkg::MODE_COUNT, 20'h55555, 20'h00000);
      queue_item(koc_pkg::MODE_DUMP,  20'hAAAAA, 20'h55555);

      queue_random(35);
      wait_quiet();

      send_idle_pct = 63;
      recv_idle_pct = 7;
      queue_random(35);
      wait_quiet();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(35);
      // show the table once more after everything has landed
      queue_item(koc_pkg::MODE_DUMP, rand_field(), rand_field(), 1'b1);
      wait_quiet();
      repeat (16) @(posedge clock);

      $display("Sent %0d items (%0d dumps) and checked %0d results.",
               items_sent, dump_items, results_checked);
      $display("Table held %0d keys; %0d overflow refusals, %0d hits at the count limit.",
               tab_used, overflow_hits, saturated_hits);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d failures in total", fail_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d items queued and %0d results outstanding",
               key_item_q.size(), tally_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
